// File: src/pbd_pkg.sv
// Shared types and constants for the pixel binning downscaler.
// Used by every module in src; depends on nothing.
package pbd_pkg;

  localparam int PIX_W       = 16;
  localparam int BIN_W       = 5;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 9;
  localparam int SUM_W       = 24;
  localparam int MULT_W      = 16;
  localparam int MASK_W      = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int PHASE_W     = 5;
  localparam int SPAN_W      = 16;
  localparam int MAX_BIN     = 16;
  localparam int SHIFT_TERMS = 16;
  localparam int OQ_DEPTH    = 8;
  localparam int OQ_PTR_W    = 3;
  localparam int OQ_CNT_W    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_FACTOR     = 3'd0,
    CFG_ORIGIN_X       = 3'd1,
    CFG_ORIGIN_Y       = 3'd2,
    CFG_OUT_WIDTH      = 3'd3,
    CFG_OUT_HEIGHT     = 3'd4,
    CFG_AVG_INT_MULT   = 3'd5,
    CFG_AVG_SHIFT_MASK = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CLIP_LOAD,
    CLIP_DIV,
    CLIP_FIT,
    CLIP_SPAN,
    CLIP_RDY
  } clip_state_t;

  // crop window limits after clipping to the frame
  typedef struct packed {
    logic              ready;
    logic [BIN_W-1:0]  bin;
    logic [COL_W-1:0]  cols;
    logic [ROW_W-1:0]  rows;
    logic [SPAN_W-1:0] x_end;
    logic [SPAN_W-1:0] y_end;
  } win_t;

  // per-pixel control carried along the accumulate stage
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             first;
    logic             emit;
    logic             bypass;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } acc_meta_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } res_t;

endpackage

// File: src/pbd_clip.sv
// Crop window sizing: clamps the bin factor and clips the window to the frame.
// Restoring divider, one quotient bit per cycle. Depends on pbd_pkg.
module pbd_clip #(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  logic [pbd_pkg::BIN_W-1:0]  bin_factor,
  input  logic [pbd_pkg::COL_W-1:0]  origin_x,
  input  logic [pbd_pkg::ROW_W-1:0]  origin_y,
  input  logic [pbd_pkg::COL_W-1:0]  out_width,
  input  logic [pbd_pkg::ROW_W-1:0]  out_height,
  output pbd_pkg::win_t              win
);

  localparam int FMAX  = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
  localparam int DVW   = $clog2(FMAX + 1);
  localparam int CNT_W = $clog2(DVW + 1);
  localparam int PX_W  = pbd_pkg::BIN_W + pbd_pkg::COL_W;
  localparam int PY_W  = pbd_pkg::BIN_W + pbd_pkg::ROW_W;
  localparam int SW    = pbd_pkg::SPAN_W;

  pbd_pkg::clip_state_t state, state_next;

  logic [pbd_pkg::BIN_W-1:0]  bin;
  logic [DVW-1:0]             dvd_x, dvd_y;
  logic [pbd_pkg::BIN_W-1:0]  rem_x, rem_y;
  logic                       zero_x, zero_y, over_x, over_y;
  logic [CNT_W-1:0]           cnt;
  logic [pbd_pkg::COL_W-1:0]  cols;
  logic [pbd_pkg::ROW_W-1:0]  rows;
  logic [SW-1:0]              x_end, y_end;

  logic [pbd_pkg::BIN_W-1:0]  b_clamp;
  logic [PX_W-1:0]            prod_x;
  logic [PY_W-1:0]            prod_y;
  logic [pbd_pkg::BIN_W:0]    trial_x, trial_y;

  always_comb begin
    priority if (bin_factor == '0) begin
      b_clamp = pbd_pkg::BIN_W'(1);
    end else if (bin_factor > pbd_pkg::BIN_W'(pbd_pkg::MAX_BIN)) begin
      b_clamp = pbd_pkg::BIN_W'(pbd_pkg::MAX_BIN);
    end else begin
      b_clamp = bin_factor;
    end
    prod_x  = PX_W'(b_clamp) * PX_W'(out_width);
    prod_y  = PY_W'(b_clamp) * PY_W'(out_height);
    trial_x = {rem_x, dvd_x[DVW-1]};
    trial_y = {rem_y, dvd_y[DVW-1]};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pbd_pkg::CLIP_LOAD: state_next = pbd_pkg::CLIP_DIV;
      pbd_pkg::CLIP_DIV:  state_next = (cnt == CNT_W'(DVW - 1)) ? pbd_pkg::CLIP_FIT
                                                                 : pbd_pkg::CLIP_DIV;
      pbd_pkg::CLIP_FIT:  state_next = pbd_pkg::CLIP_SPAN;
      pbd_pkg::CLIP_SPAN: state_next = pbd_pkg::CLIP_RDY;
      pbd_pkg::CLIP_RDY:  state_next = pbd_pkg::CLIP_RDY;
      default:            state_next = pbd_pkg::CLIP_LOAD;
    endcase
    if (restart) begin
      state_next = pbd_pkg::CLIP_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbd_pkg::CLIP_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      pbd_pkg::CLIP_LOAD: begin
        bin    <= b_clamp;
        zero_x <= SW'(origin_x) >= SW'(FRAME_WIDTH);
        zero_y <= SW'(origin_y) >= SW'(FRAME_HEIGHT);
        dvd_x  <= (SW'(origin_x) >= SW'(FRAME_WIDTH)) ? '0
                  : DVW'(SW'(FRAME_WIDTH) - SW'(origin_x));
        dvd_y  <= (SW'(origin_y) >= SW'(FRAME_HEIGHT)) ? '0
                  : DVW'(SW'(FRAME_HEIGHT) - SW'(origin_y));
        over_x <= (SW'(origin_x) + SW'(prod_x)) > SW'(FRAME_WIDTH);
        over_y <= (SW'(origin_y) + SW'(prod_y)) > SW'(FRAME_HEIGHT);
        rem_x  <= '0;
        rem_y  <= '0;
        cnt    <= '0;
      end
      pbd_pkg::CLIP_DIV: begin
        if (trial_x >= {1'b0, bin}) begin
          rem_x <= pbd_pkg::BIN_W'(trial_x - {1'b0, bin});
          dvd_x <= {dvd_x[DVW-2:0], 1'b1};
        end else begin
          rem_x <= trial_x[pbd_pkg::BIN_W-1:0];
          dvd_x <= {dvd_x[DVW-2:0], 1'b0};
        end
        if (trial_y >= {1'b0, bin}) begin
          rem_y <= pbd_pkg::BIN_W'(trial_y - {1'b0, bin});
          dvd_y <= {dvd_y[DVW-2:0], 1'b1};
        end else begin
          rem_y <= trial_y[pbd_pkg::BIN_W-1:0];
          dvd_y <= {dvd_y[DVW-2:0], 1'b0};
        end
        cnt <= CNT_W'(cnt + 1'b1);
      end
      pbd_pkg::CLIP_FIT: begin
        // quotient is below the request whenever it is chosen, so it fits
        cols <= zero_x ? '0 : (over_x ? pbd_pkg::COL_W'(dvd_x) : out_width);
        rows <= zero_y ? '0 : (over_y ? pbd_pkg::ROW_W'(dvd_y) : out_height);
      end
      pbd_pkg::CLIP_SPAN: begin
        x_end <= SW'(origin_x) + SW'(PX_W'(bin) * PX_W'(cols));
        y_end <= SW'(origin_y) + SW'(PY_W'(bin) * PY_W'(rows));
      end
      default: ;
    endcase
  end

  always_comb begin
    win.ready = (state == pbd_pkg::CLIP_RDY);
    win.bin   = bin;
    win.cols  = cols;
    win.rows  = rows;
    win.x_end = x_end;
    win.y_end = y_end;
  end

  a_restart_blocks : assert property (@(posedge clk) disable iff (rst)
    restart |=> !win.ready)
    else $error("window limits reported ready right after a config write");

endmodule

// File: src/pbd_accum.sv
// Column accumulator memory with read-modify-write and one-deep write forwarding.
// Depends on pbd_pkg.
module pbd_accum #(
  parameter int DEPTH = 640,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_valid,
  input  logic [IDX_W-1:0]           rd_idx,
  input  pbd_pkg::acc_meta_t         rd_meta,
  output logic                       out_valid,
  output logic [pbd_pkg::SUM_W-1:0]  out_sum,
  output pbd_pkg::acc_meta_t         out_meta
);

  logic [pbd_pkg::SUM_W-1:0] mem [DEPTH];
  logic [pbd_pkg::SUM_W-1:0] rdata;

  logic                      p1_v;
  logic [IDX_W-1:0]          p1_idx;
  pbd_pkg::acc_meta_t        p1_meta;

  // last write, covers a read issued in the same cycle as that write
  logic                      fw_v;
  logic [IDX_W-1:0]          fw_idx;
  logic [pbd_pkg::SUM_W-1:0] fw_sum;

  logic [pbd_pkg::SUM_W-1:0] base, sum;

  always_comb begin
    base = (fw_v && (fw_idx == p1_idx)) ? fw_sum : rdata;
    sum  = p1_meta.first ? pbd_pkg::SUM_W'(p1_meta.pix)
                         : pbd_pkg::SUM_W'(base + pbd_pkg::SUM_W'(p1_meta.pix));
  end

  always_ff @(posedge clk) begin
    if (p1_v) begin
      mem[p1_idx] <= sum;
    end
    if (rd_valid) begin
      rdata <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      fw_v <= 1'b0;
    end else begin
      p1_v <= rd_valid;
      fw_v <= p1_v;
    end
    p1_idx  <= rd_idx;
    p1_meta <= rd_meta;
    fw_idx  <= p1_idx;
    fw_sum  <= sum;
  end

  assign out_valid = p1_v && p1_meta.emit;
  assign out_sum   = sum;
  assign out_meta  = p1_meta;

  a_idx_range : assert property (@(posedge clk) disable iff (rst)
    p1_v |-> ({1'b0, p1_idx} < (IDX_W + 1)'(DEPTH)))
    else $error("accumulator index past the memory depth");

endmodule

// File: src/pbd_scale.sv
// Block sum scaling: multiplier plus masked shift terms, low 16 bits, two stages.
// Bypass passes the pixel through unscaled. Depends on pbd_pkg.
module pbd_scale (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [pbd_pkg::SUM_W-1:0]  in_sum,
  input  pbd_pkg::acc_meta_t         in_meta,
  input  logic [pbd_pkg::MULT_W-1:0] mult,
  input  logic [pbd_pkg::MASK_W-1:0] mask,
  output logic                       out_valid,
  output pbd_pkg::res_t              out_res,
  output logic [1:0]                 busy
);

  localparam int PW = pbd_pkg::PIX_W;

  logic [2*PW-1:0]    sum_ext;
  logic [2*PW-1:0]    prod_full;
  logic [PW-1:0]      term [16];
  logic [PW-1:0]      part [4];

  logic               a_v;
  logic [PW-1:0]      a_prod;
  logic [PW-1:0]      a_part [4];
  pbd_pkg::acc_meta_t a_meta;

  logic               b_v;
  pbd_pkg::res_t      b_res;

  always_comb begin
    sum_ext   = (2*PW)'(in_sum);
    prod_full = (2*PW)'(mult) * (2*PW)'(in_sum[PW-1:0]);
    for (int i = 0; i < 16; i++) begin
      term[i] = (mask[i] && (i < pbd_pkg::SHIFT_TERMS)) ? sum_ext[i+1 +: PW] : '0;
    end
    for (int g = 0; g < 4; g++) begin
      part[g] = PW'(term[4*g] + term[4*g+1] + term[4*g+2] + term[4*g+3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else begin
      a_v <= in_valid;
      b_v <= a_v;
    end
    a_prod <= prod_full[PW-1:0];
    for (int g = 0; g < 4; g++) begin
      a_part[g] <= part[g];
    end
    a_meta <= in_meta;
    b_res.value <= a_meta.bypass ? a_meta.pix
                   : PW'(a_prod + a_part[0] + a_part[1] + a_part[2] + a_part[3]);
    b_res.col   <= a_meta.col;
    b_res.row   <= a_meta.row;
    b_res.last  <= a_meta.last;
  end

  assign out_valid = b_v;
  assign out_res   = b_res;
  assign busy      = 2'(a_v) + 2'(b_v);

  a_latency : assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##2 out_valid)
    else $error("scaled result did not appear two cycles after its sum");

endmodule

// File: src/pbd_outq.sv
// Result queue between the scaling pipeline and the output channel.
// Depends on pbd_pkg.
module pbd_outq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  pbd_pkg::res_t                 push_res,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pbd_pkg::res_t                 out_res,
  output logic [pbd_pkg::OQ_CNT_W-1:0]  count
);

  pbd_pkg::res_t                 q [pbd_pkg::OQ_DEPTH];
  logic [pbd_pkg::OQ_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic                          pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_res   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= pbd_pkg::OQ_PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= pbd_pkg::OQ_PTR_W'(rd_ptr + 1'b1);
      end
      count <= pbd_pkg::OQ_CNT_W'(count + pbd_pkg::OQ_CNT_W'(push)
                                        - pbd_pkg::OQ_CNT_W'(pop));
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && (count == pbd_pkg::OQ_CNT_W'(pbd_pkg::OQ_DEPTH))))
    else $error("result queue overflow");

endmodule

// File: src/pixel_binning_downscaler_core.sv
// Pixel binning downscaler: one pixel item per cycle while in_ready is high; a
// result passes the accumulate, scale and add registers, then a queue of 8 toward
// the output. Sustains 1 item/cycle while the queue has room; the column-sum
// read-modify-write sets that loop. Reset (synchronous, active high) and every
// config write rerun the window sizing divider: in_ready is low during each
// write and until the divider has gone through its load, divide, fit and span
// states after the last write or after reset is released. Column sums are not
// cleared; the first pixel of a block overwrites its entry.
module pixel_binning_downscaler_core #(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [pbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbd_pkg::CFG_W-1:0]    cfg_data,
  // pixel input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pbd_pkg::PIX_W-1:0]    pixel,
  input  logic                         frame_start,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pbd_pkg::PIX_W-1:0]    avg_value,
  output logic [pbd_pkg::COL_W-1:0]    out_col,
  output logic [pbd_pkg::ROW_W-1:0]    out_row,
  output logic                         last
);

  localparam int RCW   = $clog2(FRAME_WIDTH);
  localparam int RRW   = $clog2(FRAME_HEIGHT);
  localparam int IDX_W = $clog2(FRAME_WIDTH);
  localparam int SW    = pbd_pkg::SPAN_W;
  localparam int PH    = pbd_pkg::PHASE_W;
  localparam int CW    = pbd_pkg::COL_W;
  localparam int RW    = pbd_pkg::ROW_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [pbd_pkg::BIN_W-1:0]  bin_factor;
  logic [CW-1:0]              origin_x;
  logic [RW-1:0]              origin_y;
  logic [CW-1:0]              out_width;
  logic [RW-1:0]              out_height;
  logic [pbd_pkg::MULT_W-1:0] avg_int_mult;
  logic [pbd_pkg::MASK_W-1:0] avg_shift_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_factor     <= pbd_pkg::BIN_W'(1);
      origin_x       <= '0;
      origin_y       <= '0;
      out_width      <= CW'(640);
      out_height     <= RW'(480);
      avg_int_mult   <= '0;
      avg_shift_mask <= '0;
    end else if (cfg_we) begin
      unique case (pbd_pkg::cfg_idx_t'(cfg_index))
        pbd_pkg::CFG_BIN_FACTOR:     bin_factor     <= cfg_data[pbd_pkg::BIN_W-1:0];
        pbd_pkg::CFG_ORIGIN_X:       origin_x       <= cfg_data[CW-1:0];
        pbd_pkg::CFG_ORIGIN_Y:       origin_y       <= cfg_data[RW-1:0];
        pbd_pkg::CFG_OUT_WIDTH:      out_width      <= cfg_data[CW-1:0];
        pbd_pkg::CFG_OUT_HEIGHT:     out_height     <= cfg_data[RW-1:0];
        pbd_pkg::CFG_AVG_INT_MULT:   avg_int_mult   <= cfg_data[pbd_pkg::MULT_W-1:0];
        pbd_pkg::CFG_AVG_SHIFT_MASK: avg_shift_mask <= cfg_data[pbd_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Window limits (clamped bin, clipped output size, raw end coordinates)
  // ---------------------------------------------------------------------------
  pbd_pkg::win_t win;

  pbd_clip #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_clip (
    .clk        (clk),
    .rst        (rst),
    .restart    (cfg_we),
    .bin_factor (bin_factor),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .out_width  (out_width),
    .out_height (out_height),
    .win        (win)
  );

  // ---------------------------------------------------------------------------
  // Raster position and block counters
  // ---------------------------------------------------------------------------
  logic [RCW-1:0] raw_col;
  logic [RRW-1:0] raw_row;
  logic [PH-1:0]  col_phase, row_phase;
  logic [CW-1:0]  cur_col;
  logic [RW-1:0]  cur_row;

  logic [RCW-1:0] raw_col_next;
  logic [RRW-1:0] raw_row_next;
  logic [PH-1:0]  col_phase_next, row_phase_next;
  logic [CW-1:0]  cur_col_next;
  logic [RW-1:0]  cur_row_next;

  // values seen by this item after frame_start and limit wrap
  logic [RCW-1:0] rc;
  logic [RRW-1:0] rr;
  logic [PH-1:0]  c0, r0, cp, rp, b_ph;
  logic [CW-1:0]  oc0, oc;
  logic [RW-1:0]  orow;
  logic           in_win, first, emit, at_last;
  logic [PH-1:0]  cp_inc, rp_inc;
  logic [CW:0]    oc_inc;
  logic [RCW:0]   rc_inc;
  logic [RRW:0]   rr_inc;

  logic           accept;
  assign accept = in_valid && in_ready;

  always_comb begin
    rc   = frame_start ? '0 : raw_col;
    rr   = frame_start ? '0 : raw_row;
    c0   = frame_start ? '0 : col_phase;
    r0   = frame_start ? '0 : row_phase;
    oc0  = frame_start ? '0 : cur_col;
    orow = frame_start ? '0 : cur_row;

    b_ph = PH'(win.bin);
    cp   = (c0 >= b_ph) ? '0 : c0;
    rp   = (r0 >= b_ph) ? '0 : r0;
    oc   = (oc0 >= win.cols) ? '0 : oc0;

    in_win = (SW'(rc) >= SW'(origin_x)) && (SW'(rc) < win.x_end) &&
             (SW'(rr) >= SW'(origin_y)) && (SW'(rr) < win.y_end);

    first   = (cp == '0) && (rp == '0);
    emit    = (cp == PH'(b_ph - 1'b1)) && (rp == PH'(b_ph - 1'b1));
    at_last = (oc == CW'(win.cols - 1'b1)) && (orow == RW'(win.rows - 1'b1));

    // block and output counters advance only for cropped pixels; frame start and frame wrap clear them
    col_phase_next = c0;
    row_phase_next = r0;
    cur_col_next   = oc0;
    cur_row_next   = orow;
    cp_inc = PH'(cp + 1'b1);
    rp_inc = PH'(rp + 1'b1);
    oc_inc = (CW+1)'(oc) + 1'b1;
    if (in_win) begin
      row_phase_next = rp;
      cur_col_next   = oc;
      if (cp_inc >= b_ph) begin
        col_phase_next = '0;
        if (oc_inc >= (CW+1)'(win.cols)) begin
          cur_col_next = '0;
          if (rp_inc >= b_ph) begin
            row_phase_next = '0;
            cur_row_next   = RW'(orow + 1'b1);
          end else begin
            row_phase_next = rp_inc;
          end
        end else begin
          cur_col_next = CW'(oc_inc);
        end
      end else begin
        col_phase_next = cp_inc;
      end
    end

    // raw raster position; the frame wraps on its own after the last pixel
    rc_inc = (RCW+1)'(rc) + 1'b1;
    rr_inc = (RRW+1)'(rr) + 1'b1;
    raw_col_next = RCW'(rc_inc);
    raw_row_next = rr;
    if (rc_inc >= (RCW+1)'(FRAME_WIDTH)) begin
      raw_col_next = '0;
      raw_row_next = RRW'(rr_inc);
      if (rr_inc >= (RRW+1)'(FRAME_HEIGHT)) begin
        raw_row_next   = '0;
        col_phase_next = '0;
        row_phase_next = '0;
        cur_col_next   = '0;
        cur_row_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_col   <= '0;
      raw_row   <= '0;
      col_phase <= '0;
      row_phase <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
    end else if (accept) begin
      raw_col   <= raw_col_next;
      raw_row   <= raw_row_next;
      col_phase <= col_phase_next;
      row_phase <= row_phase_next;
      cur_col   <= cur_col_next;
      cur_row   <= cur_row_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Column accumulation (memory read at accept, add and write in the next cycle)
  // ---------------------------------------------------------------------------
  pbd_pkg::acc_meta_t        acc_in_meta, acc_out_meta;
  logic                      acc_valid;
  logic [pbd_pkg::SUM_W-1:0] acc_sum;

  always_comb begin
    acc_in_meta.pix    = pixel;
    acc_in_meta.first  = first;
    acc_in_meta.emit   = emit;
    acc_in_meta.bypass = (win.bin == pbd_pkg::BIN_W'(1));
    acc_in_meta.col    = oc;
    acc_in_meta.row    = orow;
    acc_in_meta.last   = at_last;
  end

  pbd_accum #(
    .DEPTH (FRAME_WIDTH)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .rd_valid  (accept && in_win),
    .rd_idx    (IDX_W'(oc)),
    .rd_meta   (acc_in_meta),
    .out_valid (acc_valid),
    .out_sum   (acc_sum),
    .out_meta  (acc_out_meta)
  );

  // ---------------------------------------------------------------------------
  // Scaling and result queue
  // ---------------------------------------------------------------------------
  logic                          sc_valid;
  pbd_pkg::res_t                 sc_res, q_res;
  logic [1:0]                    sc_busy;
  logic [pbd_pkg::OQ_CNT_W-1:0]  q_count;
  logic [pbd_pkg::OQ_CNT_W:0]    pending;

  pbd_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (acc_valid),
    .in_sum    (acc_sum),
    .in_meta   (acc_out_meta),
    .mult      (avg_int_mult),
    .mask      (avg_shift_mask),
    .out_valid (sc_valid),
    .out_res   (sc_res),
    .busy      (sc_busy)
  );

  pbd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (sc_valid),
    .push_res  (sc_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (q_res),
    .count     (q_count)
  );

  // every result already in flight has a queue slot reserved
  assign pending = (pbd_pkg::OQ_CNT_W+1)'(q_count) + (pbd_pkg::OQ_CNT_W+1)'(acc_valid)
                 + (pbd_pkg::OQ_CNT_W+1)'(sc_busy);
  assign in_ready = win.ready && !cfg_we &&
                    (pending < (pbd_pkg::OQ_CNT_W+1)'(pbd_pkg::OQ_DEPTH));

  assign avg_value = q_res.value;
  assign out_col   = q_res.col;
  assign out_row   = q_res.row;
  assign last      = q_res.last;

endmodule

// File: dv/pbd_result_checker.sv
// Scoreboard for the pixel binning downscaler: tracks register writes, predicts the
// binned results from every accepted pixel item and compares accepted results in order.
// Depends on pbd_pkg for widths, register indexes and the result struct.
module pbd_result_checker #(
  parameter int FRAME_W = 640,
  parameter int FRAME_H = 480
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [pbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [pbd_pkg::PIX_W-1:0]     pixel,
  input  logic                  frame_start,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [pbd_pkg::PIX_W-1:0]     avg_value,
  input  logic [pbd_pkg::COL_W-1:0]     out_col,
  input  logic [pbd_pkg::ROW_W-1:0]     out_row,
  input  logic                  last,
  output int                    mismatch_count,
  output int                    bins_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import pbd_pkg::*;

  // register copies
  logic [BIN_W-1:0]  bin_r;
  logic [COL_W-1:0]  ox_r;
  logic [ROW_W-1:0]  oy_r;
  logic [COL_W-1:0]  w_r;
  logic [ROW_W-1:0]  h_r;
  logic [MULT_W-1:0] mult_r;
  logic [MASK_W-1:0] mask_r;

  // raster position, phase inside the block, block coordinates
  int unsigned col_pos, row_pos, sub_x, sub_y, bin_x, bin_y;
  logic [SUM_W-1:0] acc_mem [FRAME_W];

  res_t binned_q [$];
  res_t want;

  task automatic home_position();
    col_pos = 0;
    row_pos = 0;
    sub_x   = 0;
    sub_y   = 0;
    bin_x   = 0;
    bin_y   = 0;
  endtask

  // whole blocks of the requested count that fit between origin and frame edge
  function automatic int unsigned fit_bins(int unsigned org, int unsigned req,
                                           int unsigned side, int unsigned lim);
    if (org >= lim) return 0;
    if (org + side * req > lim) return (lim - org) / side;
    return req;
  endfunction

  function automatic logic [PIX_W-1:0] weigh_sum(logic [SUM_W-1:0] s);
    logic [63:0] acc;
    acc = 64'(mult_r) * 64'(s);
    for (int i = 0; i < SHIFT_TERMS; i++)
      if (mask_r[i]) acc += 64'(s >> (i + 1));
    return acc[PIX_W-1:0];
  endfunction

  task automatic bin_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int unsigned side, cw, ch, idx;
    logic [SUM_W-1:0] s;
    res_t r;
    if (fs) home_position();
    side = bin_r;
    if (side < 1) side = 1;
    if (side > MAX_BIN) side = MAX_BIN;
    cw = fit_bins(ox_r, w_r, side, FRAME_W);
    ch = fit_bins(oy_r, h_r, side, FRAME_H);
    if (col_pos >= ox_r && col_pos < ox_r + side * cw &&
        row_pos >= oy_r && row_pos < oy_r + side * ch) begin
      idx = (bin_x < FRAME_W) ? bin_x : 0;
      if (sub_x >= side) sub_x = 0;
      if (sub_y >= side) sub_y = 0;
      if (bin_x >= cw) begin
        bin_x = 0;
        idx   = 0;
      end
      // first pixel of a block overwrites the column entry
      if (sub_x == 0 && sub_y == 0) s = SUM_W'(pix);
      else s = acc_mem[idx] + SUM_W'(pix);
      acc_mem[idx] = s;
      if (sub_x == side - 1 && sub_y == side - 1) begin
        r.value = (side == 1) ? pix : weigh_sum(s);
        r.col   = bin_x[COL_W-1:0];
        r.row   = bin_y[ROW_W-1:0];
        r.last  = (bin_x == cw - 1 && bin_y == ch - 1);
        binned_q.push_back(r);
      end
      sub_x++;
      if (sub_x >= side) begin
        sub_x = 0;
        bin_x++;
        if (bin_x >= cw) begin
          bin_x = 0;
          sub_y++;
          if (sub_y >= side) begin
            sub_y = 0;
            bin_y++;
          end
        end
      end
    end
    col_pos++;
    if (col_pos >= FRAME_W) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= FRAME_H) home_position();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      bin_r  = 1;
      ox_r   = 0;
      oy_r   = 0;
      w_r    = COL_W'(FRAME_W);
      h_r    = ROW_W'(FRAME_H);
      mult_r = 0;
      mask_r = 0;
      home_position();
      binned_q.delete();
    end else begin
      // results leave in a later cycle than their pixel, so check them first
      if (out_valid && out_ready) begin
        if (binned_q.size() == 0) begin
          $error("unexpected result: avg_value %0h out_col %0d out_row %0d last %0b",
                 avg_value, out_col, out_row, last);
          mismatch_count++;
        end else begin
          want = binned_q.pop_front();
          if (avg_value !== want.value) begin
            $error("avg_value: expected %0h, actual %0h", want.value, avg_value);
            mismatch_count++;
          end
          if (out_col !== want.col) begin
            $error("out_col: expected %0d, actual %0d", want.col, out_col);
            mismatch_count++;
          end
          if (out_row !== want.row) begin
            $error("out_row: expected %0d, actual %0d", want.row, out_row);
            mismatch_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BIN_FACTOR:     bin_r  = cfg_data[BIN_W-1:0];
          CFG_ORIGIN_X:       ox_r   = cfg_data[COL_W-1:0];
          CFG_ORIGIN_Y:       oy_r   = cfg_data[ROW_W-1:0];
          CFG_OUT_WIDTH:      w_r    = cfg_data[COL_W-1:0];
          CFG_OUT_HEIGHT:     h_r    = cfg_data[ROW_W-1:0];
          CFG_AVG_INT_MULT:   mult_r = cfg_data[MULT_W-1:0];
          CFG_AVG_SHIFT_MASK: mask_r = cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) bin_pixel(pixel, frame_start);
    end
    bins_owed = binned_q.size();
  end

endmodule

// File: dv/tb_pixel_binning_downscaler_core.sv
// Top of the downscaler testbench: clock, reset, register programming and pixel stimulus.
// Prediction and comparison live in pbd_result_checker; depends on pbd_pkg and the core.
module tb_pixel_binning_downscaler_core;
  timeunit 1ns;
  timeprecision 1ps;
  import pbd_pkg::*;

  localparam int FRAME_W       = 640;
  localparam int FRAME_H       = 480;
  localparam int SETTLE_CYCLES = 8;     // covers the 3-stage pipe behind the last result
  localparam int QUIET_LIMIT   = 1000;  // cycles with no item moving on either channel
  localparam int RAND_ITEMS    = 100;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [PIX_W-1:0]     pixel;
  logic                 frame_start;
  logic                 out_valid;
  logic                 out_ready;
  logic [PIX_W-1:0]     avg_value;
  logic [COL_W-1:0]     out_col;
  logic [ROW_W-1:0]     out_row;
  logic                 last;

  int mismatch_count;
  int bins_owed;
  int quiet_cycles;
  bit idle_on = 1'b1;   // random gaps/stalls on both channels when set

  pixel_binning_downscaler_core #(
    .FRAME_WIDTH  (FRAME_W),
    .FRAME_HEIGHT (FRAME_H)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .avg_value   (avg_value),
    .out_col     (out_col),
    .out_row     (out_row),
    .last        (last)
  );

  pbd_result_checker #(
    .FRAME_W (FRAME_W),
    .FRAME_H (FRAME_H)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel          (pixel),
    .frame_start    (frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .avg_value      (avg_value),
    .out_col        (out_col),
    .out_row        (out_row),
    .last           (last),
    .mismatch_count (mismatch_count),
    .bins_owed      (bins_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: any cycle with no item moving counts toward the limit. The longest
  // legal quiet stretch is a drain, seven register writes and the sizing pass
  // after them, well under the limit.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: ready most of the time, stalls in random bursts.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Mostly random pixels with the two extremes mixed in often.
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  // valid is only dropped for a gap, so it never toggles within one step.
  task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    pixel       <= pix;
    frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write.
  task automatic put_reg(input cfg_idx_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(negedge clk);
  endtask

  // One crop/bin setting: wait until the block is idle, program all seven
  // registers, then stream n_pix pixels starting at a frame start. With
  // with_noise an occasional stray frame start cuts a block short.
  task automatic run_window(input int side, input int ox, input int oy, input int w,
                            input int h, input int mult, input int mask,
                            input int n_pix, input bit with_idle, input bit with_noise);
    logic fs;
    while (bins_owed != 0) @(negedge clk);
    // pixels outside the window leave no result but may still be in the pipe
    repeat (SETTLE_CYCLES) @(negedge clk);
    put_reg(CFG_BIN_FACTOR, side);
    put_reg(CFG_ORIGIN_X, ox);
    put_reg(CFG_ORIGIN_Y, oy);
    put_reg(CFG_OUT_WIDTH, w);
    put_reg(CFG_OUT_HEIGHT, h);
    put_reg(CFG_AVG_INT_MULT, mult);
    put_reg(CFG_AVG_SHIFT_MASK, mask);
    cfg_we   <= 1'b0;
    idle_on  = with_idle;
    for (int k = 0; k < n_pix; k++) begin
      fs = (k == 0) || (with_noise && $urandom_range(0, 511) == 0);
      push_pixel(pick_pixel(), fs);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int side, ox, oy, w, h, mult, mask, n_pix;
    int rand_items;
    logic [PIX_W-1:0] edge_pix [8];
    edge_pix = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001,
                 16'h7FFF, 16'hAAAA, 16'h5555, 16'h00FF};
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = CFG_BIN_FACTOR;
    cfg_data    = '0;
    in_valid    = 1'b0;
    pixel       = '0;
    frame_start = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: bin 1 over the full frame, every pixel comes straight out.
    // A frame start partway through must restart the output column at zero.
    for (int k = 0; k < 20; k++)
      push_pixel((k < 8) ? edge_pix[k] : pick_pixel(), (k == 0) || (k == 12));
    in_valid <= 1'b0;

    // 2x2 blocks, three across from column 2; largest multiplier and mask.
    // Pixels of one block column arrive back to back on the same entry.
    run_window(2, 2, 0, 3, 1, 16'hFFFF, 16'hFFFF, FRAME_W + 8, 1'b1, 1'b0);
    // bin 0 behaves as 1, bin above the maximum behaves as the maximum
    run_window(0, 5, 0, 4, 2, 0, 0, 40, 1'b1, 1'b0);
    run_window(20, 0, 0, 1, 1, 1, 16'h8001, 20, 1'b1, 1'b0);
    // origin beyond the frame, column then row
    run_window(1, 700, 0, 5, 5, 1, 0, 20, 1'b1, 1'b0);
    run_window(1, 0, 500, 5, 5, 1, 0, 20, 1'b1, 1'b0);
    // zero width, then zero height
    run_window(1, 0, 0, 0, 1, 1, 0, 20, 1'b1, 1'b0);
    run_window(1, 0, 0, 5, 0, 1, 0, 20, 1'b1, 1'b0);

    // Random settings on short runs: only the first raw row is reached, so
    // larger bins and lower origins check that nothing comes out.
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      side = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 1;
      ox   = $urandom_range(0, 20);
      oy   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, FRAME_H - 1) : 0;
      w    = ($urandom_range(0, 3) == 0) ? FRAME_W : $urandom_range(1, 20);
      h    = ($urandom_range(0, 7) == 0) ? FRAME_H : $urandom_range(1, 3);
      case ($urandom_range(0, 7))
        0:       mult = 0;
        1:       mult = 16'hFFFF;
        default: mult = $urandom_range(0, 16'hFFFF);
      endcase
      mask  = $urandom_range(0, 16'hFFFF);
      n_pix = $urandom_range(10, 30);
      run_window(side, ox, oy, w, h, mult, mask, n_pix, $urandom_range(0, 3) != 0, 1'b1);
      rand_items += n_pix;
    end

    // Last part, no idling: a one-row window of 20 columns; last fires on its
    // final column and the pixels after it produce nothing.
    run_window(1, $urandom_range(0, 10), 0, 20, 1, $urandom_range(0, 16'hFFFF),
               $urandom_range(0, 16'hFFFF), 40, 1'b0, 1'b0);

    while (bins_owed != 0) @(negedge clk);
    repeat (4 * SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && bins_owed == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
src/pbd_pkg.sv
src/pbd_clip.sv
src/pbd_accum.sv
src/pbd_scale.sv
src/pbd_outq.sv
src/pixel_binning_downscaler_core.sv
dv/pbd_result_checker.sv
dv/tb_pixel_binning_downscaler_core.sv
